/* hw/rtl/sse_pkg.sv */
// Package for the string stack engine: payload structs, operation and
// status codes, and the command and status structs between controller
// and datapath. No dependencies.
package sse_pkg;

   localparam int CAP_W = 7;
   localparam int LEN_W = 7;
   localparam int CHAR_W = 8;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic [1:0] FUNC_PUSH  = 2'd0;
   localparam logic [1:0] FUNC_POP   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [2:0] ST_ACCEPT = 3'd0;
   localparam logic [2:0] ST_REJECT = 3'd1;
   localparam logic [2:0] ST_CHAR   = 3'd2;
   localparam logic [2:0] ST_EMPTY  = 3'd3;
   localparam logic [2:0] ST_UNDER  = 3'd4;

   typedef struct packed {
      logic [1:0]        func;
      logic [CHAR_W-1:0] char_in;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [CHAR_W-1:0] char_out;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic push_char;
      logic push_term;
      logic pop_under;
      logic pop_start;
      logic clear;
      logic scan_rd;
      logic scan_step;
      logic pop_finish;
      logic emit_rd;
      logic emit_out;
   } cmd_type;

   typedef struct packed {
      logic stack_under;
      logic start_zero;
      logic scan_nonzero;
      logic span_zero;
      logic emit_last;
      logic rsp_free;
   } sts_type;

endpackage

/* hw/rtl/string_stack_engine_unit.sv */
// Top level of the string stack engine: controller and datapath.
// Depends on sse_pkg, sse_ctrl, sse_dp and sse_ram.

// A push character or a clear never leaves the idle state, and a push
// terminator or a pop of an empty stack returns its word in the result
// register in the next cycle. A pop first scans back through the single
// read port of the byte store, one character at a time, to find the
// previous terminator, then streams the string character by character,
// holding while the result channel stalls. A new request word is taken
// only when the controller is idle and the result register is empty or
// being emptied. The capacity register may be written at any cycle the
// block is idle.
module string_stack_engine_unit #(
   parameter int STORE_DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  sse_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output sse_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [sse_pkg::CAP_W-1:0] csr_data
);
   import sse_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   sse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .sts       (sts),
      .cmd       (cmd)
   );

   sse_dp #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* hw/rtl/sse_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/sse_ctrl.sv */
// Controller state machine of the string stack engine: input handshake and
// sequencing of the pop scan and character stream. Depends on sse_pkg.
module sse_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sse_pkg::req_type req_data,
   input  sse_pkg::sts_type sts,
   output sse_pkg::cmd_type cmd
);
   import sse_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_POP_CHK = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_EMIT_RD = 3'd3;
   localparam logic [2:0] S_EMIT_WR = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE) && sts.rsp_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.func)
                  FUNC_PUSH: begin
                     if (req_data.char_in != '0) begin
                        cmd.push_char = 1'b1;
                     end else begin
                        cmd.push_term = 1'b1;
                     end
                  end
                  FUNC_POP: begin
                     if (sts.stack_under) begin
                        cmd.pop_under = 1'b1;
                     end else begin
                        cmd.pop_start = 1'b1;
                        state_in      = S_POP_CHK;
                     end
                  end
                  FUNC_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP_CHK: begin
            if (sts.start_zero) begin
               cmd.pop_finish = 1'b1;
               state_in       = sts.span_zero ? S_IDLE : S_EMIT_RD;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.scan_nonzero) begin
               cmd.scan_step = 1'b1;
               state_in      = S_POP_CHK;
            end else begin
               cmd.pop_finish = 1'b1;
               state_in       = sts.span_zero ? S_IDLE : S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = S_EMIT_WR;
         end
         S_EMIT_WR: begin
            if (sts.rsp_free) begin
               cmd.emit_out = 1'b1;
               state_in     = sts.emit_last ? S_IDLE : S_EMIT_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/sse_dp.sv */
// Datapath of the string stack engine: stack pointers, capacity register,
// byte store and result register. Depends on sse_pkg and sse_ram.
module sse_dp #(
   parameter int STORE_DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sse_pkg::req_type           req_data,
   input  sse_pkg::cmd_type           cmd,
   output sse_pkg::sts_type           sts,
   input  logic                       csr_valid,
   input  logic [sse_pkg::CAP_W-1:0]  csr_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output sse_pkg::rsp_type           rsp_data
);
   import sse_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);
   localparam logic [CAP_W-1:0] DEPTH_CAP = CAP_W'(STORE_DEPTH);

   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   logic [CAP_W-1:0]  top_ff, top_in;
   logic [LEN_W-1:0]  pending_ff, pending_in;
   logic [AW-1:0]     start_ff, start_in;
   logic [AW-1:0]     end_ff, end_in;
   logic [AW-1:0]     emit_ff, emit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [CAP_W-1:0]  cap;
   logic [CAP_W:0]    pos;
   logic [CAP_W:0]    pos_next;
   logic [CAP_W-1:0]  top_dec;
   logic              fits;
   logic              wr_en;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [CHAR_W-1:0] rd_data;

   assign cap      = (capacity_ff > DEPTH_CAP) ? DEPTH_CAP : capacity_ff;
   assign pos      = {1'b0, top_ff} + {1'b0, pending_ff};
   assign pos_next = pos + 1'b1;
   assign fits     = pos < {1'b0, cap};
   assign top_dec  = top_ff - 1'b1;

   assign wr_en   = (cmd.push_char || cmd.push_term) && fits;
   assign rd_en   = cmd.scan_rd || cmd.emit_rd;
   assign rd_addr = cmd.scan_rd ? (start_ff - 1'b1) : emit_ff;

   sse_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos[AW-1:0]),
      .wr_data (req_data.char_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sts.stack_under  = (top_ff == '0) || (top_ff > DEPTH_CAP);
   assign sts.start_zero   = (start_ff == '0);
   assign sts.scan_nonzero = (rd_data != '0);
   assign sts.span_zero    = (start_ff == end_ff);
   assign sts.emit_last    = (({1'b0, emit_ff} + 1'b1) == {1'b0, end_ff});
   assign sts.rsp_free     = !rsp_valid_ff || rsp_ready;

   always_comb begin
      capacity_in  = capacity_ff;
      top_in       = top_ff;
      pending_in   = pending_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         capacity_in = csr_data;
      end
      if (cmd.push_char) begin
         if (pending_ff != '1) begin
            pending_in = pending_ff + 1'b1;
         end
      end
      if (cmd.push_term) begin
         pending_in   = '0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{status: fits ? ST_ACCEPT : ST_REJECT, char_out: '0, last: 1'b1};
         if (fits) begin
            top_in = pos_next[CAP_W-1:0];
         end
      end
      if (cmd.pop_under) begin
         pending_in   = '0;
         top_in       = '0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{status: ST_UNDER, char_out: '0, last: 1'b1};
      end
      if (cmd.pop_start) begin
         pending_in = '0;
         end_in     = top_dec[AW-1:0];
         start_in   = top_dec[AW-1:0];
      end
      if (cmd.clear) begin
         top_in     = '0;
         pending_in = '0;
      end
      if (cmd.scan_step) begin
         start_in = start_ff - 1'b1;
      end
      if (cmd.pop_finish) begin
         top_in  = CAP_W'(start_ff);
         emit_in = start_ff;
         if (sts.span_zero) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{status: ST_EMPTY, char_out: '0, last: 1'b1};
         end
      end
      if (cmd.emit_out) begin
         emit_in      = emit_ff + 1'b1;
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{status: ST_CHAR, char_out: rd_data, last: sts.emit_last};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         top_ff       <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         top_ff       <= top_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      end_ff      <= end_in;
      emit_ff     <= emit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
